FILE: src/m2inv_pkg.sv
// ---------------------------------------------------------------------------
// m2inv_pkg: shared types and constants for the 2x2 matrix inverse
// Field widths of the reciprocal divider and the sideband that rides along it.
// ---------------------------------------------------------------------------
package m2inv_pkg;

    localparam int unsigned Q_FRAC = 16;
    localparam int unsigned ELEM_W = 32;
    // Truncated determinant magnitude: |det| < 2^63, shifted right by Q_FRAC
    localparam int unsigned DQ_W   = 47;
    // Quotient of 2^32 / dq holds up to 2^32
    localparam int unsigned QUO_W  = 33;
    // Partial remainder never exceeds twice the 2^32 numerator
    localparam int unsigned REM_W  = 34;
    localparam int unsigned THR_W  = 31;

    localparam logic [ELEM_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] NEG_LIMIT = 32'h8000_0000;

    // Per-matrix data that travels beside the divider stages
    typedef struct packed {
        logic signed [ELEM_W-1:0] a11;
        logic signed [ELEM_W-1:0] a12;
        logic signed [ELEM_W-1:0] a21;
        logic signed [ELEM_W-1:0] a22;
        logic                     dneg;
        logic                     singular;
        logic                     det_ovf;
        logic        [ELEM_W-1:0] det;
    } side_t;

endpackage

FILE: src/matrix2x2_inverse_top.sv
// ---------------------------------------------------------------------------
// matrix2x2_inverse_top: 2x2 Q16.16 matrix inverse by adjugate
// Determinant, singular test, pipelined reciprocal and adjugate scaling.
// ---------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  in      | in_valid / in_stall    | a11 a12 a21 a22
//  out     | out_valid / out_stall  | inv11 inv12 inv21 inv22 determinant
//          |                        | singular overflow
//  cfg     | cfg_valid / cfg_ready  | cfg_data (singular_threshold)
//
//  One transaction per clock sustained while the output is not stalled; the
//  path runs through 4 determinant stages, 33 divider stages (one quotient
//  bit each, the longest part), 2 scaling stages and the output register.
//  Reset clears valid bits and sets the threshold to 1; there is no
//  clearing pass. A stalled result moves into a skid register; while that
//  is occupied in_stall is high and the whole pipeline holds.
// ---------------------------------------------------------------------------
module matrix2x2_inverse_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] a11,
    input  logic signed [31:0] a12,
    input  logic signed [31:0] a21,
    input  logic signed [31:0] a22,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] inv11,
    output logic signed [31:0] inv12,
    output logic signed [31:0] inv21,
    output logic signed [31:0] inv22,
    output logic signed [31:0] determinant,
    output logic               singular,
    output logic               overflow,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        cfg_data
);
    import m2inv_pkg::*;

    typedef struct packed {
        logic [ELEM_W-1:0] inv11;
        logic [ELEM_W-1:0] inv12;
        logic [ELEM_W-1:0] inv21;
        logic [ELEM_W-1:0] inv22;
        logic [ELEM_W-1:0] det;
        logic              singular;
        logic              overflow;
    } res_t;

    logic              en;
    logic [THR_W-1:0]  thr_reg;

    // stage 1: the two cross products
    logic                     s1_vld_reg;
    logic signed [ELEM_W-1:0] s1_a11_reg, s1_a12_reg, s1_a21_reg, s1_a22_reg;
    logic signed [63:0]       s1_p1_reg, s1_p2_reg;
    // stage 2: exact Q32.32 determinant
    logic                     s2_vld_reg;
    logic signed [ELEM_W-1:0] s2_a11_reg, s2_a12_reg, s2_a21_reg, s2_a22_reg;
    logic signed [63:0]       s2_d_reg;
    // stage 3: truncated magnitude
    logic                     s3_vld_reg;
    logic signed [ELEM_W-1:0] s3_a11_reg, s3_a12_reg, s3_a21_reg, s3_a22_reg;
    logic                     s3_dneg_reg;
    logic [DQ_W-1:0]          s3_dq_reg;
    // stage 4: singular test and saturated determinant
    logic                     s4_vld_reg;
    logic [DQ_W-1:0]          s4_dq_reg;
    side_t                    s4_side_reg;

    logic [63:0]              d_mag;
    logic [DQ_W-1:0]          det_lim;
    side_t                    s4_side_next;

    // divider output
    logic                     dv_vld;
    logic [QUO_W-1:0]         dv_quo;
    side_t                    dv_side;

    // stage 5: saturated reciprocal and adjugate magnitudes
    logic                     s5_vld_reg;
    side_t                    s5_side_reg;
    logic [ELEM_W-1:0]        s5_r_reg;
    logic                     s5_rovf_reg;
    logic [ELEM_W-1:0]        s5_emag_reg [4];
    logic [3:0]               s5_eneg_reg;
    logic [QUO_W-1:0]         r_lim;
    logic [ELEM_W-1:0]        adj_next [4];
    logic [3:0]               eneg_next;

    // stage 6: products
    logic                     s6_vld_reg;
    side_t                    s6_side_reg;
    logic                     s6_rovf_reg;
    logic [63:0]              s6_prod_reg [4];
    logic [3:0]               s6_eneg_reg;

    // output register and skid
    res_t                     exit_res;
    logic [ELEM_W-1:0]        pbits [4];
    logic [3:0]               povf;
    logic                     out_vld_reg, skid_vld_reg, take;
    res_t                     out_reg, skid_reg;

    // Hold every stage while the skid register is occupied
    assign en        = !skid_vld_reg;
    assign in_stall  = skid_vld_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_W'(1);
        else if (cfg_valid && cfg_ready)
            thr_reg <= cfg_data;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= dv_vld;
            s6_vld_reg <= s5_vld_reg;
        end
    end

    // Determinant magnitude never reaches 2^63, so bit 63 of d_mag is clear
    assign d_mag   = s2_d_reg[63] ? (64'd0 - 64'(s2_d_reg)) : 64'(s2_d_reg);
    assign det_lim = s3_dneg_reg ? DQ_W'(NEG_LIMIT) : DQ_W'(POS_LIMIT);

    always_comb
    begin
        s4_side_next.a11      = s3_a11_reg;
        s4_side_next.a12      = s3_a12_reg;
        s4_side_next.a21      = s3_a21_reg;
        s4_side_next.a22      = s3_a22_reg;
        s4_side_next.dneg     = s3_dneg_reg;
        // a zero determinant is singular even with a zero threshold
        s4_side_next.singular = (s3_dq_reg == '0)
                              || (s3_dq_reg < {{(DQ_W-THR_W){1'b0}}, thr_reg});
        s4_side_next.det_ovf  = s3_dq_reg > det_lim;
        if (s3_dq_reg > det_lim)
            s4_side_next.det = s3_dneg_reg ? NEG_LIMIT : POS_LIMIT;
        else if (s3_dneg_reg)
            s4_side_next.det = ELEM_W'(0) - s3_dq_reg[ELEM_W-1:0];
        else
            s4_side_next.det = s3_dq_reg[ELEM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_a11_reg  <= a11;
            s1_a12_reg  <= a12;
            s1_a21_reg  <= a21;
            s1_a22_reg  <= a22;
            s1_p1_reg   <= a11 * a22;
            s1_p2_reg   <= a12 * a21;

            s2_a11_reg  <= s1_a11_reg;
            s2_a12_reg  <= s1_a12_reg;
            s2_a21_reg  <= s1_a21_reg;
            s2_a22_reg  <= s1_a22_reg;
            s2_d_reg    <= s1_p1_reg - s1_p2_reg;

            s3_a11_reg  <= s2_a11_reg;
            s3_a12_reg  <= s2_a12_reg;
            s3_a21_reg  <= s2_a21_reg;
            s3_a22_reg  <= s2_a22_reg;
            s3_dneg_reg <= s2_d_reg[63];
            s3_dq_reg   <= d_mag[62:Q_FRAC];

            s4_dq_reg   <= s3_dq_reg;
            s4_side_reg <= s4_side_next;
        end
    end

    m2inv_recip u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s4_vld_reg),
        .in_dq    (s4_dq_reg),
        .in_side  (s4_side_reg),
        .out_vld  (dv_vld),
        .out_quo  (dv_quo),
        .out_side (dv_side)
    );

    // Adjugate (a22, -a12, -a21, a11) as sign and magnitude; -(-2^31) stays exact
    assign r_lim = dv_side.dneg ? QUO_W'(NEG_LIMIT) : QUO_W'(POS_LIMIT);

    always_comb
    begin
        adj_next[0]  = dv_side.a22[31] ? (ELEM_W'(0) - dv_side.a22) : dv_side.a22;
        adj_next[1]  = dv_side.a12[31] ? (ELEM_W'(0) - dv_side.a12) : dv_side.a12;
        adj_next[2]  = dv_side.a21[31] ? (ELEM_W'(0) - dv_side.a21) : dv_side.a21;
        adj_next[3]  = dv_side.a11[31] ? (ELEM_W'(0) - dv_side.a11) : dv_side.a11;
        eneg_next[0] = dv_side.a22[31];
        eneg_next[1] = !dv_side.a12[31];
        eneg_next[2] = !dv_side.a21[31];
        eneg_next[3] = dv_side.a11[31];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_side_reg <= dv_side;
            s5_rovf_reg <= dv_quo > r_lim;
            s5_r_reg    <= (dv_quo > r_lim) ? r_lim[ELEM_W-1:0] : dv_quo[ELEM_W-1:0];
            s5_eneg_reg <= eneg_next;
            for (int k = 0; k < 4; k++)
                s5_emag_reg[k] <= adj_next[k];

            s6_side_reg <= s5_side_reg;
            s6_rovf_reg <= s5_rovf_reg;
            s6_eneg_reg <= s5_eneg_reg;
            for (int k = 0; k < 4; k++)
                s6_prod_reg[k] <= s5_emag_reg[k] * s5_r_reg;
        end
    end

    // Truncate products to Q16.16 and saturate
    always_comb
    begin
        logic [47:0]       pmag;
        logic              pneg;
        logic [ELEM_W-1:0] plim;
        for (int k = 0; k < 4; k++)
        begin
            pmag    = s6_prod_reg[k][63:Q_FRAC];
            pneg    = (s6_eneg_reg[k] != s6_side_reg.dneg) && (pmag != '0);
            plim    = pneg ? NEG_LIMIT : POS_LIMIT;
            povf[k] = pmag > 48'(plim);
            if (povf[k])
                pmag = 48'(plim);
            pbits[k] = pneg ? (ELEM_W'(0) - pmag[ELEM_W-1:0]) : pmag[ELEM_W-1:0];
        end
        exit_res.inv11    = s6_side_reg.singular ? '0 : pbits[0];
        exit_res.inv12    = s6_side_reg.singular ? '0 : pbits[1];
        exit_res.inv21    = s6_side_reg.singular ? '0 : pbits[2];
        exit_res.inv22    = s6_side_reg.singular ? '0 : pbits[3];
        exit_res.det      = s6_side_reg.det;
        exit_res.singular = s6_side_reg.singular;
        exit_res.overflow = s6_side_reg.det_ovf
                          || (!s6_side_reg.singular && (s6_rovf_reg || (povf != '0)));
    end

    // Output register with skid: a transaction leaving the pipeline while the
    // output is held parks in the skid register
    assign take = out_vld_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || take)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
                out_vld_reg  <= s6_vld_reg;
        end
        else if (s6_vld_reg && en)
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || take)
            out_reg <= skid_vld_reg ? skid_reg : exit_res;
        else if (en)
            skid_reg <= exit_res;
    end

    assign out_valid   = out_vld_reg;
    assign inv11       = out_reg.inv11;
    assign inv12       = out_reg.inv12;
    assign inv21       = out_reg.inv21;
    assign inv22       = out_reg.inv22;
    assign determinant = out_reg.det;
    assign singular    = out_reg.singular;
    assign overflow    = out_reg.overflow;

    // The skid register is only ever filled behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid occupied with empty output register");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && out_stall && s6_vld_reg))
        else $error("skid filled without a stalled output");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_reg.singular) |->
            (out_reg.inv11 == '0 && out_reg.inv12 == '0
             && out_reg.inv21 == '0 && out_reg.inv22 == '0))
        else $error("singular result with nonzero inverse");

endmodule

FILE: src/m2inv_recip.sv
// ---------------------------------------------------------------------------
// m2inv_recip: pipelined reciprocal divider
// Forms 2^32 / dq one quotient bit per stage, restoring, sideband alongside.
// ---------------------------------------------------------------------------
module m2inv_recip (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [m2inv_pkg::DQ_W-1:0]    in_dq,
    input  m2inv_pkg::side_t              in_side,
    output logic                          out_vld,
    output logic [m2inv_pkg::QUO_W-1:0]   out_quo,
    output m2inv_pkg::side_t              out_side
);
    import m2inv_pkg::*;

    logic [QUO_W-1:0] vld_reg;
    logic [REM_W-1:0] rem_reg  [QUO_W-1];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    logic [DQ_W-1:0]  dq_reg   [QUO_W];
    side_t            side_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_stage
        logic             v_in;
        logic [REM_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [DQ_W-1:0]  dq_in;
        side_t            side_in;
        logic [REM_W-1:0] trial;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign v_in    = in_vld;
            assign rem_in  = '0;
            assign quo_in  = '0;
            assign dq_in   = in_dq;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = vld_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign quo_in  = quo_reg[i-1];
            assign dq_in   = dq_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        // numerator 2^32: only its top bit, taken by the first stage, is set
        assign trial = {rem_in[REM_W-2:0], (i == 0) ? 1'b1 : 1'b0};
        assign ge    = {{(DQ_W-REM_W){1'b0}}, trial} >= dq_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[i]  <= {quo_in[QUO_W-2:0], ge};
                dq_reg[i]   <= dq_in;
                side_reg[i] <= side_in;
            end
        end

        if (i < QUO_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                    rem_reg[i] <= ge ? (trial - dq_in[REM_W-1:0]) : trial;
            end
        end
    end

    assign out_vld  = vld_reg[QUO_W-1];
    assign out_quo  = quo_reg[QUO_W-1];
    assign out_side = side_reg[QUO_W-1];

endmodule

FILE: tb/matrix2x2_inverse_checker.sv
// ---------------------------------------------------------------------------
// matrix2x2_inverse_checker: scoreboard for the 2x2 matrix inverse
// Watches the input, output and threshold channels, predicts each inverse
// and compares it field by field with what the block returns.
// ---------------------------------------------------------------------------
module matrix2x2_inverse_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] a11,
    input  logic signed [31:0] a12,
    input  logic signed [31:0] a21,
    input  logic signed [31:0] a22,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] inv11,
    input  logic signed [31:0] inv12,
    input  logic signed [31:0] inv21,
    input  logic signed [31:0] inv22,
    input  logic signed [31:0] determinant,
    input  logic               singular,
    input  logic               overflow,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [30:0]        cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 inverses_seen,
    output int                 singular_seen,
    output int                 overflow_seen
);
    import m2inv_pkg::*;

    typedef struct packed {
        logic [31:0] e11;
        logic [31:0] e12;
        logic [31:0] e21;
        logic [31:0] e22;
        logic [31:0] det;
        logic        sing;
        logic        ovf;
    } inverse_t;

    inverse_t          inverse_q[$];
    logic [THR_W-1:0]  threshold;

    // Saturate a sign/magnitude Q16.16 value to 32 bits
    function automatic logic [31:0] clamp_q16(input logic neg, input logic [63:0] mag,
                                              inout logic ovf);
        logic [63:0] lim;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (mag > lim) begin
            mag = lim;
            ovf = 1'b1;
        end
        return neg ? 32'(-mag) : mag[31:0];
    endfunction

    function automatic inverse_t invert(input logic signed [31:0] m11,
                                        input logic signed [31:0] m12,
                                        input logic signed [31:0] m21,
                                        input logic signed [31:0] m22,
                                        input logic [THR_W-1:0] thr);
        inverse_t           r;
        logic signed [63:0] d;
        logic signed [63:0] adj [4];
        logic [63:0]        dmag, dq, rmag, emag, pmag;
        logic               dneg, eneg, ovf;
        logic [31:0]        prod [4];
        ovf  = 1'b0;
        d    = 64'(m11) * 64'(m22) - 64'(m12) * 64'(m21);
        dneg = d < 0;
        dmag = dneg ? -d : d;
        dq   = dmag >> Q_FRAC;
        r.det = clamp_q16(dneg, dq, ovf);
        if (dq == 0 || dq < {33'd0, thr}) begin
            r.e11 = '0; r.e12 = '0; r.e21 = '0; r.e22 = '0;
            r.sing = 1'b1;
            r.ovf  = ovf;
            return r;
        end
        rmag = 64'h1_0000_0000 / dq;
        if (rmag > (dneg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
            rmag = dneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            ovf  = 1'b1;
        end
        adj[0] = 64'(m22);
        adj[1] = -64'(m12);
        adj[2] = -64'(m21);
        adj[3] = 64'(m11);
        for (int k = 0; k < 4; k++) begin
            eneg = adj[k] < 0;
            emag = eneg ? -adj[k] : adj[k];
            pmag = (emag * rmag) >> Q_FRAC;
            prod[k] = clamp_q16((eneg != dneg) && pmag != 0, pmag, ovf);
        end
        r.e11 = prod[0]; r.e12 = prod[1]; r.e21 = prod[2]; r.e22 = prod[3];
        r.sing = 1'b0;
        r.ovf  = ovf;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n) begin
        inverse_t want, got;
        if (!rst_n) begin
            threshold     <= 31'd1;
            fail_count    <= 0;
            pending       <= 0;
            inverses_seen <= 0;
            singular_seen <= 0;
            overflow_seen <= 0;
            inverse_q.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                threshold <= cfg_data;
            if (in_valid && !in_stall)
                inverse_q.push_back(invert(a11, a12, a21, a22, threshold));
            if (out_valid && !out_stall) begin
                got = '{inv11, inv12, inv21, inv22, determinant, singular, overflow};
                inverses_seen <= inverses_seen + 1;
                singular_seen <= singular_seen + int'(singular);
                overflow_seen <= overflow_seen + int'(overflow);
                if (inverse_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: %p", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = inverse_q.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p got %p", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= inverse_q.size();
        end
    end
endmodule

FILE: tb/matrix2x2_inverse_top_tb.sv
// ---------------------------------------------------------------------------
// matrix2x2_inverse_top_tb: stimulus and verdict for the matrix inverse
// Drives directed and random matrices under three idling patterns and
// several singular thresholds; the checker does the prediction.
// ---------------------------------------------------------------------------
module matrix2x2_inverse_top_tb;

    localparam int LATENCY  = 40;
    localparam int WATCHDOG = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] a11, a12, a21, a22;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] inv11, inv12, inv21, inv22, determinant;
    logic               singular, overflow;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [30:0]        cfg_data;

    int fail_count, pending, inverses_seen, singular_seen, overflow_seen;
    int send_idle_pct, recv_idle_pct;
    int quiet_cycles;
    int matrices_sent;

    matrix2x2_inverse_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .a11(a11), .a12(a12), .a21(a21), .a22(a22),
        .out_valid(out_valid), .out_stall(out_stall),
        .inv11(inv11), .inv12(inv12), .inv21(inv21), .inv22(inv22),
        .determinant(determinant), .singular(singular), .overflow(overflow),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    matrix2x2_inverse_checker i_checker (.*);

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver back-pressure: stall at random according to the current phase
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog: count cycles in which no transaction moves on either channel
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            quiet_cycles <= 0;
        else begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("watchdog expired with %0d results outstanding", pending);
                $display("** matrix2x2_inverse_top: FAILED **");
                $finish;
            end
        end
    end

    // Random element: mostly moderate values, sometimes full range or extremes
    function automatic logic [31:0] pick_element();
        case ($urandom_range(9))
            0:       return $urandom();
            1:       return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2:       return 32'($signed($urandom_range(8)) - 4);
            3, 4:    return 32'($signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000);
            default: return 32'($signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000);
        endcase
    endfunction

    // Present one matrix and hold it until accepted
    task automatic send_matrix(input logic [31:0] m11, input logic [31:0] m12,
                               input logic [31:0] m21, input logic [31:0] m22);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        a11 <= m11; a12 <= m12; a21 <= m21; a22 <= m22;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        matrices_sent++;
    endtask

    // Drop valid and wait until every expected result has come
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Write the threshold while the block is idle
    task automatic set_threshold(input logic [30:0] thr);
        cfg_valid <= 1'b1;
        cfg_data  <= thr;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_matrices(input int count);
        logic [31:0] r;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(7) == 0) begin
                // Near-singular: second row a multiple of the first plus noise
                r = pick_element();
                send_matrix(r, 32'h0002_0000, r + $urandom_range(3), 32'h0002_0000);
            end else begin
                send_matrix(pick_element(), pick_element(), pick_element(), pick_element());
            end
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        a11 = '0; a12 = '0; a21 = '0; a22 = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        matrices_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, zero, extremes, reciprocal saturation,
        // wide determinant and negated minimum element
        send_matrix(32'h0001_0000, 0, 0, 32'h0001_0000);
        send_matrix(0, 0, 0, 0);
        send_matrix(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF);
        send_matrix(32'h8000_0000, 0, 0, 32'h8000_0000);
        send_matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_matrix(1, 0, 0, 32'h0001_0000);
        send_matrix(32'h0000_0100, 0, 0, 32'h0000_0100);
        send_matrix(32'h0000_0100, 0, 0, 32'hFFFF_FF00);
        send_matrix(32'h8000_0000, 32'h0001_0000, 0, 32'h0001_0000);
        send_matrix(32'h0001_0000, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000);
        send_matrix(32'h0002_0000, 32'h0001_0000, 32'h0004_0000, 32'h0002_0000);
        send_matrix(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_matrix(32'h0000_8000, 0, 0, 32'h0001_0001);
        // Hold off until the pipeline has emptied completely
        drain();

        // Zero threshold: only a determinant that truncates to zero is singular
        set_threshold(31'd0);
        send_matrix(32'h0000_0100, 0, 0, 32'h0000_0100);
        send_matrix(0, 32'h0001_0000, 0, 32'h0001_0000);
        send_matrix(32'h0001_0000, 0, 0, 32'h0001_0000);
        drain();

        // Phase 1: sender idles lightly, receiver heavily
        send_idle_pct = 15;
        recv_idle_pct = 71;
        set_threshold(31'h7FFF_FFFF);
        random_matrices(150);
        drain();
        set_threshold(31'd1);
        random_matrices(300);
        drain();

        // Phase 2: roles swapped
        send_idle_pct = 71;
        recv_idle_pct = 15;
        set_threshold(31'h0001_0000);
        random_matrices(450);
        drain();

        // Phase 3: no idling at all
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_threshold(31'($urandom()));
        random_matrices(300);
        drain();
        set_threshold(31'd16);
        random_matrices(700);
        drain();

        $display("covered %0d matrices, %0d results: %0d singular, %0d saturated",
                 matrices_sent, inverses_seen, singular_seen, overflow_seen);
        $display("thresholds 0, 1, 16, 1.0, random and maximum; three idling patterns");
        if (fail_count == 0)
            $display("** matrix2x2_inverse_top: PASSED **");
        else
            $display("** matrix2x2_inverse_top: FAILED **");
        $finish;
    end
endmodule

FILE: files.f
src/m2inv_pkg.sv
src/m2inv_recip.sv
src/matrix2x2_inverse_top.sv
tb/matrix2x2_inverse_checker.sv
tb/matrix2x2_inverse_top_tb.sv
